// ===== sv/jsu_pkg.sv =====
package jsu_pkg;

    // Decoder mode codes; the other two codes of the field act as normal
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESCAPE = 3'd1,
        MODE_HEX1   = 3'd2,
        MODE_HEX2   = 3'd3,
        MODE_HEX3   = 3'd4,
        MODE_HEX4   = 3'd5
    } mode_t;

    // Input beat
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    // Result beat
    typedef struct packed {
        logic [7:0]  out_data;
        logic        out_end;
        logic        out_error;
        logic [15:0] out_length;
    } out_t;

    // All results caused by one input byte: up to three data bytes, then
    // an optional terminator
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      ndata;
        logic            term;
        logic            err;
        logic [15:0]     length;
    } pkt_t;

    // Packet queue between the decoder and the serializer
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

endpackage

// ===== sv/jsu_front.sv =====
module jsu_front
    import jsu_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  in_t  din,
    output logic pkt_push,
    output pkt_t pkt
);

    localparam int CW = (LENGTH_BITS >= 16) ? 16 : LENGTH_BITS;
    localparam logic [CW+1:0] LIMIT = {2'b00, {CW{1'b1}}};

    mode_t          mode_reg, mode_next;
    logic [11:0]    hex_reg, hex_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           err_reg, err_next;
    logic           stop_reg, stop_next;

    logic [2:0][7:0] data;
    logic [1:0]      nd;
    logic [3:0]      digit;
    logic            digit_ok;
    logic [15:0]     cp;
    logic [CW+1:0]   sum, sum_sat, len_sum, len_sat;
    logic            term;

    // Hex digit of either case
    always_comb
    begin
        digit_ok = 1'b1;
        digit    = 4'd0;
        if (din.in_byte >= "0" && din.in_byte <= "9")
        begin
            digit = 4'(din.in_byte - 8'h30);
        end
        else if (din.in_byte >= "A" && din.in_byte <= "F")
        begin
            digit = 4'(din.in_byte - 8'h37);
        end
        else if (din.in_byte >= "a" && din.in_byte <= "f")
        begin
            digit = 4'(din.in_byte - 8'h57);
        end
        else
        begin
            digit_ok = 1'b0;
        end
    end

    assign cp = {hex_reg, digit};

    // Decode one byte
    always_comb
    begin
        mode_next = mode_reg;
        hex_next  = hex_reg;
        err_next  = err_reg;
        stop_next = stop_reg;
        data      = '0;
        nd        = 2'd0;
        if (!stop_reg)
        begin
            unique case (mode_reg)
                MODE_ESCAPE:
                begin
                    mode_next = MODE_NORMAL;
                    nd        = 2'd1;
                    unique case (din.in_byte)
                        "\"", "\\", "/": data[0] = din.in_byte;
                        "b": data[0] = 8'h08;
                        "f": data[0] = 8'h0C;
                        "n": data[0] = 8'h0A;
                        "r": data[0] = 8'h0D;
                        "t": data[0] = 8'h09;
                        "u":
                        begin
                            nd        = 2'd0;
                            mode_next = MODE_HEX1;
                            hex_next  = '0;
                        end
                        default:
                        begin
                            nd        = 2'd0;
                            err_next  = 1'b1;
                            stop_next = 1'b1;
                        end
                    endcase
                end
                MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4:
                begin
                    if (!digit_ok)
                    begin
                        err_next  = 1'b1;
                        stop_next = 1'b1;
                        mode_next = MODE_NORMAL;
                    end
                    else if (mode_reg != MODE_HEX4)
                    begin
                        hex_next = {hex_reg[7:0], digit};
                        unique case (mode_reg)
                            MODE_HEX1: mode_next = MODE_HEX2;
                            MODE_HEX2: mode_next = MODE_HEX3;
                            default:   mode_next = MODE_HEX4;
                        endcase
                    end
                    else
                    begin
                        mode_next = MODE_NORMAL;
                        hex_next  = '0;
                        // UTF-8 encode, one to three bytes
                        if (cp < 16'h0080)
                        begin
                            nd      = 2'd1;
                            data[0] = cp[7:0];
                        end
                        else if (cp < 16'h0800)
                        begin
                            nd      = 2'd2;
                            data[0] = 8'hC0 | {3'b000, cp[10:6]};
                            data[1] = 8'h80 | {2'b00, cp[5:0]};
                        end
                        else
                        begin
                            nd      = 2'd3;
                            data[0] = 8'hE0 | {4'h0, cp[15:12]};
                            data[1] = 8'h80 | {2'b00, cp[11:6]};
                            data[2] = 8'h80 | {2'b00, cp[5:0]};
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                    if (din.in_byte == 8'h00)
                    begin
                        stop_next = 1'b1;
                    end
                    else if (din.in_byte == "\\")
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        nd      = 2'd1;
                        data[0] = din.in_byte;
                    end
                end
            endcase
        end
        // Unfinished escape at the end of the string
        term = din.in_last;
        if (term && !stop_next && mode_next != MODE_NORMAL)
        begin
            err_next = 1'b1;
        end
    end

    // Saturating length count
    always_comb
    begin
        sum     = {2'b00, count_reg} + {{CW{1'b0}}, nd};
        sum_sat = (sum > LIMIT) ? LIMIT : sum;
        len_sum = sum_sat + {{(CW+1){1'b0}}, 1'b1};
        len_sat = (len_sum > LIMIT) ? LIMIT : len_sum;
    end

    assign count_next = sum_sat[CW-1:0];

    // Packet for the queue
    always_comb
    begin
        pkt.data   = data;
        pkt.ndata  = nd;
        pkt.term   = term;
        pkt.err    = err_next;
        pkt.length = 16'(len_sat[CW-1:0]);
    end

    assign pkt_push = accept && (term || nd != 2'd0);

    // Per-string state; cleared after the terminator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            hex_reg   <= '0;
            count_reg <= '0;
            err_reg   <= 1'b0;
            stop_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (term)
            begin
                mode_reg  <= MODE_NORMAL;
                hex_reg   <= '0;
                count_reg <= '0;
                err_reg   <= 1'b0;
                stop_reg  <= 1'b0;
            end
            else
            begin
                mode_reg  <= mode_next;
                hex_reg   <= hex_next;
                count_reg <= count_next;
                err_reg   <= err_next;
                stop_reg  <= stop_next;
            end
        end
    end

endmodule

// ===== sv/jsu_queue.sv =====
module jsu_queue
    import jsu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  pkt_t wdata,
    input  logic pop,
    output logic full,
    output logic valid,
    output pkt_t rdata
);

    pkt_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign valid = (cnt_reg != '0);
    assign rdata = slot_reg[rptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/jsu_back.sv =====
module jsu_back
    import jsu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pkt_valid,
    input  pkt_t pkt,
    output logic pkt_pop,
    input  logic pop,
    output logic empty,
    output out_t dout
);

    logic [1:0] sel_reg;
    out_t       out_reg;
    logic       ovalid_reg;
    logic       load;
    logic [2:0] beats;
    logic       last_beat;
    out_t       beat;

    assign beats     = {1'b0, pkt.ndata} + {2'b00, pkt.term};
    assign last_beat = ({1'b0, sel_reg} + 3'd1) == beats;
    assign load      = pkt_valid && (!ovalid_reg || pop);
    assign pkt_pop   = load && last_beat;

    // Pick the current beat of the head packet
    always_comb
    begin
        beat = '0;
        if (sel_reg < pkt.ndata)
        begin
            beat.out_data = pkt.data[sel_reg];
        end
        else
        begin
            beat.out_end    = 1'b1;
            beat.out_error  = pkt.err;
            beat.out_length = pkt.length;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            sel_reg    <= '0;
        end
        else
        begin
            if (load)
            begin
                ovalid_reg <= 1'b1;
                sel_reg    <= last_beat ? 2'd0 : sel_reg + 2'd1;
            end
            else if (pop)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign empty = !ovalid_reg;
    assign dout  = out_reg;

endmodule

// ===== sv/json_string_unescape_utf8_top.sv =====
// A byte's results pass through the packet queue and then the output register.
// Throughput: one input byte per cycle while full is low; results leave at one beat per cycle while pop is held.
// A \u escape gives up to three bytes, plus a terminator on the last byte;
// the four-packet queue absorbs those bursts and raises full when it fills.
// Reset (rst_n low, asynchronous) clears the decoder state, queue pointers and output valid flag.
module json_string_unescape_utf8_top
    import jsu_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  in_t  din,
    output logic empty,
    input  logic pop,
    output out_t dout
);

    logic accept;
    logic q_push;
    logic q_pop;
    logic q_valid;
    pkt_t f_pkt;
    pkt_t q_pkt;

    assign accept = push && !full;

    jsu_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .din      (din),
        .pkt_push (q_push),
        .pkt      (f_pkt)
    );

    jsu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (f_pkt),
        .pop   (q_pop),
        .full  (full),
        .valid (q_valid),
        .rdata (q_pkt)
    );

    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (q_valid),
        .pkt       (q_pkt),
        .pkt_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .dout      (dout)
    );

`ifndef SYNTH
    // Every queued packet carries at least one beat
    a_pkt_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (f_pkt.ndata != 2'd0 || f_pkt.term))
        else $error("empty packet pushed");

    // Serializer only releases a packet that is present
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("packet queue underflow");

    // Terminator beats carry zero data, data beats carry no status
    a_term_fields: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (dout.out_end ? (dout.out_data == 8'h00 && dout.out_length != 16'h0)
                                 : (!dout.out_error && dout.out_length == 16'h0)))
        else $error("bad result beat fields");
`endif

endmodule

// ===== bench/tb_json_string_unescape_utf8_top.sv =====
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8_top;
    import jsu_pkg::*;

    // Length counter narrowed to eight bits
    localparam int          LEN_BITS = 8;
    localparam logic [15:0] CNT_MAX  = (LEN_BITS >= 16) ? 16'hFFFF
                                                        : 16'((1 << LEN_BITS) - 1);

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // Decoded control bytes
    localparam logic [7:0] BS_BYTE   = 8'h08;
    localparam logic [7:0] FF_BYTE   = 8'h0C;
    localparam logic [7:0] LF_BYTE   = 8'h0A;
    localparam logic [7:0] CR_BYTE   = 8'h0D;
    localparam logic [7:0] TAB_BYTE  = 8'h09;

    // UTF-8 framing
    localparam logic [7:0] LEAD2     = 8'hC0;
    localparam logic [7:0] LEAD3     = 8'hE0;
    localparam logic [7:0] CONT      = 8'h80;

    localparam int RX_HOLD_CYCLES = 80;

    typedef struct {
        in_t beat;
        bit  drain;
        bit  hold;
    } pend_item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic push  = 1'b0;
    logic pop   = 1'b0;
    in_t  din   = '0;
    logic full;
    logic empty;
    out_t dout;

    json_string_unescape_utf8_top #(
        .LENGTH_BITS(LEN_BITS)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .full (full),
        .din  (din),
        .empty(empty),
        .pop  (pop),
        .dout (dout)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pend_item_t  pending_q[$];
    out_t        decoded_q[$];
    logic [7:0]  str_buf[$];
    bit          mark_drain = 0;
    bit          mark_hold  = 0;

    // Decoder copy
    mode_t       dec_mode   = MODE_NORMAL;
    logic [11:0] hex_acc    = '0;
    logic [15:0] produced   = '0;
    logic        err_seen   = 1'b0;
    logic        silenced   = 1'b0;

    int fail_count  = 0;
    int beats_in    = 0;
    int beats_out   = 0;
    int strings_out = 0;
    int err_strings = 0;
    int sat_strings = 0;
    int hold_reqs   = 0;
    int hold_seen   = 0;
    int tx_gap      = 0;
    int tx_calm     = 0;
    int rx_gap      = 0;
    int rx_calm     = 0;
    int rx_hold     = 0;

    function automatic logic [15:0] count_step(logic [15:0] c);
        return (c >= CNT_MAX) ? CNT_MAX : c + 16'd1;
    endfunction

    function automatic int hex_value(logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return int'(c - CH_0);
        if (c >= CH_UA && c <= CH_UF)
            return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF)
            return int'(c - CH_LA) + 10;
        return -1;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    task automatic put_data(logic [7:0] b);
        out_t r;
        r = '0;
        r.out_data = b;
        decoded_q.push_back(r);
        produced = count_step(produced);
    endtask

    task automatic enter_error();
        err_seen = 1'b1;
        silenced = 1'b1;
        dec_mode = MODE_NORMAL;
    endtask

    // Work out every result beat caused by one input beat
    task automatic decode_beat(in_t beat);
        logic [7:0]  b;
        logic [15:0] cp;
        int          hv;
        out_t        term;
        b = beat.in_byte;
        if (!silenced)
        begin
            case (dec_mode)
                MODE_ESCAPE:
                begin
                    dec_mode = MODE_NORMAL;
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: put_data(b);
                        CH_B: put_data(BS_BYTE);
                        CH_F: put_data(FF_BYTE);
                        CH_N: put_data(LF_BYTE);
                        CH_R: put_data(CR_BYTE);
                        CH_T: put_data(TAB_BYTE);
                        CH_U:
                        begin
                            dec_mode = MODE_HEX1;
                            hex_acc  = '0;
                        end
                        default: enter_error();
                    endcase
                end
                MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4:
                begin
                    hv = hex_value(b);
                    if (hv < 0)
                        enter_error();
                    else if (dec_mode != MODE_HEX4)
                    begin
                        hex_acc  = {hex_acc[7:0], hv[3:0]};
                        dec_mode = mode_t'(dec_mode + 3'd1);
                    end
                    else
                    begin
                        cp       = {hex_acc, hv[3:0]};
                        dec_mode = MODE_NORMAL;
                        hex_acc  = '0;
                        if (cp < 16'h0080)
                            put_data(cp[7:0]);
                        else if (cp < 16'h0800)
                        begin
                            put_data(LEAD2 | {3'b0, cp[10:6]});
                            put_data(CONT | {2'b0, cp[5:0]});
                        end
                        else
                        begin
                            put_data(LEAD3 | {4'b0, cp[15:12]});
                            put_data(CONT | {2'b0, cp[11:6]});
                            put_data(CONT | {2'b0, cp[5:0]});
                        end
                    end
                end
                default:
                begin
                    dec_mode = MODE_NORMAL;
                    if (b == CH_NUL)
                        silenced = 1'b1;
                    else if (b == CH_BSLASH)
                        dec_mode = MODE_ESCAPE;
                    else
                        put_data(b);
                end
            endcase
        end
        // Terminator closes the string; an open escape counts as truncated
        if (beat.in_last)
        begin
            if (!silenced && dec_mode != MODE_NORMAL)
                err_seen = 1'b1;
            term            = '0;
            term.out_end    = 1'b1;
            term.out_error  = err_seen;
            term.out_length = count_step(produced);
            decoded_q.push_back(term);
            dec_mode = MODE_NORMAL;
            hex_acc  = '0;
            produced = '0;
            err_seen = 1'b0;
            silenced = 1'b0;
        end
    endtask

    task automatic check_result(out_t got);
        out_t want;
        if (decoded_q.size() == 0)
        begin
            $error("result beat with nothing expected: data %h end %b", got.out_data,
                   got.out_end);
            fail_count++;
        end
        else
        begin
            want = decoded_q.pop_front();
            if (got.out_data !== want.out_data)
            begin
                $error("out_data expected %h actual %h", want.out_data, got.out_data);
                fail_count++;
            end
            if (got.out_end !== want.out_end)
            begin
                $error("out_end expected %b actual %b", want.out_end, got.out_end);
                fail_count++;
            end
            if (got.out_error !== want.out_error)
            begin
                $error("out_error expected %b actual %b", want.out_error, got.out_error);
                fail_count++;
            end
            if (got.out_length !== want.out_length)
            begin
                $error("out_length expected %0d actual %0d", want.out_length,
                       got.out_length);
                fail_count++;
            end
            if (want.out_end)
            begin
                strings_out++;
                if (want.out_error)
                    err_strings++;
                if (want.out_length == CNT_MAX)
                    sat_strings++;
            end
        end
        beats_out++;
    endtask

    // Driver: one beat offered at a time, held until accepted
    always @(posedge clk)
    begin
        pend_item_t head;
        logic       go;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            go = 1'b0;
            if (push && !full)
            begin
                decode_beat(din);
                beats_in++;
            end
            if (!push || !full)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (pending_q.size() > 0)
                begin
                    head = pending_q[0];
                    if (!head.drain || decoded_q.size() == 0)
                    begin
                        void'(pending_q.pop_front());
                        din <= head.beat;
                        go = 1'b1;
                        if (head.hold)
                            hold_reqs++;
                        if (tx_calm > 0)
                        begin
                            tx_calm--;
                            tx_gap = 0;
                        end
                        else
                        begin
                            tx_gap = pick_gap();
                            if ($urandom_range(0, 24) == 0)
                                tx_calm = $urandom_range(20, 40);
                        end
                    end
                end
                push <= go;
            end
        end
    end

    // Monitor: checks each popped beat, stalls at random
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                check_result(dout);
                if (rx_calm > 0)
                begin
                    rx_calm--;
                    rx_gap = 0;
                end
                else
                begin
                    rx_gap = pick_gap();
                    if ($urandom_range(0, 24) == 0)
                        rx_calm = $urandom_range(20, 40);
                end
            end
            if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                rx_hold   = RX_HOLD_CYCLES;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            str_buf.push_back(s[i]);
    endtask

    // Move the buffered string into the pending queue, last flag on its final byte
    task automatic flush_string();
        pend_item_t it;
        for (int i = 0; i < str_buf.size(); i++)
        begin
            it.beat.in_byte = str_buf[i];
            it.beat.in_last = (i == str_buf.size() - 1);
            it.drain        = (i == 0) && mark_drain;
            it.hold         = (i == 0) && mark_hold;
            pending_q.push_back(it);
        end
        mark_drain = 0;
        mark_hold  = 0;
        str_buf.delete();
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10)
            return CH_0 + {4'b0, v};
        return (($urandom_range(0, 1) == 1) ? CH_UA : CH_LA) + {4'b0, v} - 8'd10;
    endfunction

    function automatic logic [7:0] esc_char(int k);
        case (k)
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    task automatic add_unicode(logic [15:0] cp);
        str_buf.push_back(CH_BSLASH);
        str_buf.push_back(CH_U);
        str_buf.push_back(hex_char(cp[15:12]));
        str_buf.push_back(hex_char(cp[11:8]));
        str_buf.push_back(hex_char(cp[7:4]));
        str_buf.push_back(hex_char(cp[3:0]));
    endtask

    task automatic add_plain();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        if (b == CH_BSLASH)
            b = 8'h5D;
        str_buf.push_back(b);
    endtask

    // One random string; noisy ones mix in broken escapes and stray bytes
    task automatic add_random_string();
        int  ntok;
        int  r;
        int  sel;
        bit  noisy;
        bit  stop;
        ntok  = $urandom_range(1, 8);
        noisy = ($urandom_range(0, 3) == 0);
        stop  = 0;
        for (int t = 0; t < ntok && !stop; t++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40 || (r >= 80 && !noisy))
                add_plain();
            else if (r < 60)
            begin
                str_buf.push_back(CH_BSLASH);
                str_buf.push_back(esc_char($urandom_range(0, 7)));
            end
            else if (r < 80)
            begin
                sel = $urandom_range(0, 2);
                if (sel == 0)
                    add_unicode(16'($urandom_range(0, 16'h007F)));
                else if (sel == 1)
                    add_unicode(16'($urandom_range(16'h0080, 16'h07FF)));
                else
                    add_unicode(16'($urandom_range(16'h0800, 16'hFFFF)));
            end
            else
            begin
                sel = $urandom_range(0, 4);
                case (sel)
                    0:
                    begin
                        str_buf.push_back(CH_BSLASH);
                        str_buf.push_back(8'($urandom_range(0, 255)));
                    end
                    1:
                    begin
                        str_buf.push_back(CH_BSLASH);
                        str_buf.push_back(CH_U);
                        repeat ($urandom_range(0, 3))
                            str_buf.push_back(hex_char(4'($urandom_range(0, 15))));
                        str_buf.push_back(8'($urandom_range(0, 255)));
                    end
                    2: str_buf.push_back(CH_NUL);
                    3:
                    begin
                        // escape left open at the end of the string
                        str_buf.push_back(CH_BSLASH);
                        if ($urandom_range(0, 1) == 1)
                        begin
                            str_buf.push_back(CH_U);
                            repeat ($urandom_range(0, 3))
                                str_buf.push_back(hex_char(4'($urandom_range(0, 15))));
                        end
                        stop = 1;
                    end
                    default: str_buf.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        flush_string();
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        int n_directed;
        bit hold_marked;
        bit drain_marked;

        hold_marked  = 0;
        drain_marked = 0;

        // raw high byte, escape, mixed-case hex giving three bytes on the last byte
        str_buf.push_back(8'hFF);
        add_text("\\t\\uFfFf");
        flush_string();
        // escaped zero, then a zero byte that silences the rest, last byte silent
        add_text("\\u0000A");
        str_buf.push_back(CH_NUL);
        add_text("BC");
        flush_string();
        // bad escape letter
        add_text("\\q!");
        flush_string();
        // bad hex digit on the last byte
        add_text("\\u1g");
        flush_string();
        // escape cut short by the end of the string
        add_text("\\");
        flush_string();
        // zero byte alone as the last byte
        str_buf.push_back(CH_NUL);
        flush_string();
        n_directed = pending_q.size();

        // one long receiver hold, then one pause until all results are back
        while (pending_q.size() < n_directed + 120)
        begin
            if (pending_q.size() >= n_directed + 50 && !hold_marked)
            begin
                mark_hold   = 1;
                hold_marked = 1;
            end
            if (pending_q.size() >= n_directed + 90 && !drain_marked)
            begin
                mark_drain   = 1;
                drain_marked = 1;
            end
            add_random_string();
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() > 0 || push || decoded_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Run covered %0d input beats and %0d result beats over %0d strings",
                 beats_in, beats_out, strings_out);
        $display("%0d strings ended with an error, %0d reached the length limit",
                 err_strings, sat_strings);
        if (fail_count == 0)
            $display("PASS json_string_unescape_utf8_top");
        else
            $display("FAIL json_string_unescape_utf8_top");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Timeout with %0d beats pending and %0d results outstanding",
                 pending_q.size(), decoded_q.size());
        $display("FAIL json_string_unescape_utf8_top");
        $finish;
    end

endmodule
